[rtl/i2a_pkg.sv]
package i2a_pkg;

   // Function codes on req_func
   localparam logic [1:0] FUNC_SDEC = 2'd0;
   localparam logic [1:0] FUNC_UDEC = 2'd1;
   localparam logic [1:0] FUNC_HEXL = 2'd2;
   localparam logic [1:0] FUNC_HEXU = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] HEX_LOWER_BASE = 8'h57;  // 'a' - 10
   localparam logic [7:0] HEX_UPPER_BASE = 8'h37;  // 'A' - 10

   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 16;
   localparam int BIN_BITS   = 32;

   typedef logic [2:0] step_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_NOP,
      OP_DABBLE,
      OP_SKIP,
      OP_TOTAL,
      OP_SIGN,
      OP_DIGIT
   } op_type;

   typedef enum logic [2:0] {
      CND_ALWAYS,
      CND_NO_START,
      CND_HEX,
      CND_ITER_MORE,
      CND_SKIP_MORE,
      CND_NOT_NEG,
      CND_OUT_FULL,
      CND_DIGIT_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic hex;
      logic iter_more;
      logic skip_more;
      logic neg;
      logic out_free;
      logic last_digit;
   } flags_type;

   // Program steps
   localparam step_type STEP_WAIT  = 3'd0;
   localparam step_type STEP_MODE  = 3'd1;
   localparam step_type STEP_DAB   = 3'd2;
   localparam step_type STEP_SKIP  = 3'd3;
   localparam step_type STEP_TOTAL = 3'd4;
   localparam step_type STEP_SIGN  = 3'd5;
   localparam step_type STEP_DIGIT = 3'd6;
   localparam step_type STEP_DONE  = 3'd7;

   // Microcode ROM: conditional jump to target when cond holds, else fall through.
   function automatic ctrl_word_type rom_word(step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_WAIT:  w = '{OP_IDLE,   CND_NO_START,   STEP_WAIT};
         STEP_MODE:  w = '{OP_NOP,    CND_HEX,        STEP_SKIP};
         STEP_DAB:   w = '{OP_DABBLE, CND_ITER_MORE,  STEP_DAB};
         STEP_SKIP:  w = '{OP_SKIP,   CND_SKIP_MORE,  STEP_SKIP};
         STEP_TOTAL: w = '{OP_TOTAL,  CND_NOT_NEG,    STEP_DIGIT};
         STEP_SIGN:  w = '{OP_SIGN,   CND_OUT_FULL,   STEP_SIGN};
         STEP_DIGIT: w = '{OP_DIGIT,  CND_DIGIT_MORE, STEP_DIGIT};
         STEP_DONE:  w = '{OP_NOP,    CND_ALWAYS,     STEP_WAIT};
         default:    w = '{OP_NOP,    CND_ALWAYS,     STEP_WAIT};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] digit_char(logic [3:0] n, logic upper);
      logic [7:0] code;
      if (n < 4'd10) begin
         code = CHAR_ZERO + {4'd0, n};
      end else if (upper) begin
         code = HEX_UPPER_BASE + {4'd0, n};
      end else begin
         code = HEX_LOWER_BASE + {4'd0, n};
      end
      return code;
   endfunction

endpackage

[rtl/i2a_seq.sv]
module i2a_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  i2a_pkg::flags_type      flags,
   output i2a_pkg::ctrl_word_type  ctrl,
   output i2a_pkg::step_type       step
);

   i2a_pkg::step_type step_ff;
   i2a_pkg::step_type step_in;
   logic              take;

   assign ctrl = i2a_pkg::rom_word(step_ff);
   assign step = step_ff;

   always_comb begin
      unique case (ctrl.cond)
         i2a_pkg::CND_ALWAYS:     take = 1'b1;
         i2a_pkg::CND_NO_START:   take = !flags.start;
         i2a_pkg::CND_HEX:        take = flags.hex;
         i2a_pkg::CND_ITER_MORE:  take = flags.iter_more;
         i2a_pkg::CND_SKIP_MORE:  take = flags.skip_more;
         i2a_pkg::CND_NOT_NEG:    take = !flags.neg;
         i2a_pkg::CND_OUT_FULL:   take = !flags.out_free;
         i2a_pkg::CND_DIGIT_MORE: take = !(flags.out_free && flags.last_digit);
         default:                 take = 1'b0;
      endcase
      step_in = take ? ctrl.target : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= i2a_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/integer_to_ascii_digits_core.sv]
// Converts one integer per word into ASCII text, most significant character
// first, one character per result word. Decimal modes run a bit-serial
// binary-to-BCD conversion of the 32-bit magnitude, then skip leading zero
// digits and emit a minus sign first for a negative signed value; hex modes
// skip leading zero nibbles of the 64-bit value. Output stalls hold the
// emission of each character. The 8-step microcode program sets the order;
// one word is converted at a time, and req_stall stays high until the
// sequencer has passed its done step and returned to its wait step after
// the last character is loaded into the output register.
module integer_to_ascii_digits_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_is_last,
   output logic [4:0]  rsp_char_total
);

   localparam int BCD_LSB = 64 - 4 * i2a_pkg::DEC_DIGITS;

   i2a_pkg::ctrl_word_type ctrl;
   i2a_pkg::step_type      step;
   i2a_pkg::flags_type     flags;

   logic [63:0] dig_ff, dig_in;
   logic [31:0] bin_ff, bin_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  iter_ff, iter_in;
   logic [4:0]  total_ff, total_in;
   logic        neg_ff, neg_in;
   logic        hex_ff, hex_in;
   logic        upper_ff, upper_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_code_ff, rsp_code_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [4:0]  rsp_total_ff, rsp_total_in;

   logic        start;
   logic        out_free;
   logic        skip_more;
   logic        in_neg;
   logic [31:0] mag;
   logic [63-BCD_LSB:0] bcd_adj;

   assign start     = req_valid && (step == i2a_pkg::STEP_WAIT);
   assign req_stall = (step != i2a_pkg::STEP_WAIT);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign skip_more = (dig_ff[63:60] == 4'd0) && (cnt_ff > 5'd1);

   assign in_neg = (req_func == i2a_pkg::FUNC_SDEC) && req_value[31];
   assign mag    = in_neg ? (32'd0 - req_value[31:0]) : req_value[31:0];

   always_comb begin
      for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
         if (dig_ff[BCD_LSB + 4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = dig_ff[BCD_LSB + 4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = dig_ff[BCD_LSB + 4*i +: 4];
         end
      end
   end

   assign flags = '{
      start:      start,
      hex:        hex_ff,
      iter_more:  (iter_ff != 5'd0),
      skip_more:  skip_more,
      neg:        neg_ff,
      out_free:   out_free,
      last_digit: (cnt_ff == 5'd1)
   };

   i2a_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .step  (step)
   );

   always_comb begin
      dig_in       = dig_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      iter_in      = iter_ff;
      total_in     = total_ff;
      neg_in       = neg_ff;
      hex_in       = hex_ff;
      upper_in     = upper_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_total_in = rsp_total_ff;

      unique case (ctrl.op)
         i2a_pkg::OP_IDLE: begin
            if (start) begin
               hex_in   = req_func[1];
               upper_in = (req_func == i2a_pkg::FUNC_HEXU);
               neg_in   = in_neg;
               bin_in   = mag;
               iter_in  = 5'(i2a_pkg::BIN_BITS - 1);
               if (req_func[1]) begin
                  dig_in = req_value;
                  cnt_in = 5'(i2a_pkg::HEX_DIGITS);
               end else begin
                  dig_in = '0;
                  cnt_in = 5'(i2a_pkg::DEC_DIGITS);
               end
            end
         end
         i2a_pkg::OP_DABBLE: begin
            // add 3 to digits of 5 or more, then shift the next binary bit in
            dig_in[63:BCD_LSB] = {bcd_adj[62-BCD_LSB:0], bin_ff[31]};
            bin_in  = {bin_ff[30:0], 1'b0};
            iter_in = iter_ff - 5'd1;
         end
         i2a_pkg::OP_SKIP: begin
            if (skip_more) begin
               dig_in = {dig_ff[59:0], 4'd0};
               cnt_in = cnt_ff - 5'd1;
            end
         end
         i2a_pkg::OP_TOTAL: begin
            total_in = cnt_ff + {4'd0, neg_ff};
         end
         i2a_pkg::OP_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = i2a_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_total_in = 5'd0;
            end
         end
         i2a_pkg::OP_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = i2a_pkg::digit_char(dig_ff[63:60], upper_ff);
               rsp_last_in  = (cnt_ff == 5'd1);
               rsp_total_in = (cnt_ff == 5'd1) ? total_ff : 5'd0;
               dig_in       = {dig_ff[59:0], 4'd0};
               cnt_in       = cnt_ff - 5'd1;
            end
         end
         i2a_pkg::OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_ff       <= dig_in;
      bin_ff       <= bin_in;
      cnt_ff       <= cnt_in;
      iter_ff      <= iter_in;
      total_ff     <= total_in;
      neg_ff       <= neg_in;
      hex_ff       <= hex_in;
      upper_ff     <= upper_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = rsp_code_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_char_total = rsp_total_ff;

   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> (rsp_total_ff != 5'd0) && (rsp_total_ff <= 5'd16))
      else $error("character total out of range on last word");

   a_zero_total_early: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_total_ff == 5'd0)
      else $error("nonzero character total before last word");

   a_idle_no_partial: assert property (@(posedge clock) disable iff (reset)
      (step == i2a_pkg::STEP_WAIT) |-> !(rsp_valid_ff && !rsp_last_ff))
      else $error("sequencer idle with a number only partly emitted");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (step == i2a_pkg::STEP_DIGIT) |-> (cnt_ff != 5'd0))
      else $error("digit step with no digits left");

endmodule
